// File: design/esg_pkg.sv
package esg_pkg;

  localparam int DEF_CHANNELS   = 8;
  localparam int DEF_VALUE_BITS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ADAPTIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTITY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE   = 3'd5;

  localparam logic [15:0] GAIN_RST      = 16'd19661;
  localparam logic [15:0] INTERVAL_RST  = 16'd5000;
  localparam logic [15:0] PRECISION_RST = 16'd65535;

  // operations
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // channel codes
  localparam logic [2:0] CH_AUDIO  = 3'd0;
  localparam logic [2:0] CH_CAMERA = 3'd1;
  localparam logic [2:0] CH_SCREEN = 3'd2;
  localparam logic [2:0] CH_BODY   = 3'd3;

  // threshold table slots
  localparam int LIM_AUDIO  = 0;
  localparam int LIM_CAMERA = 1;
  localparam int LIM_SCREEN = 2;
  localparam int LIM_BODY   = 3;
  localparam int LIM_OTHER  = 4;
  localparam int LIM_SLOTS  = 5;

  localparam logic [15:0] QUIET_MAX = 16'hFFFF;

  typedef struct packed {
    logic        func;
    logic [2:0]  channel;
    logic [15:0] sample_value;
    logic        semantic_flag;
    logic [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic        forward;
    logic [15:0] predicted_value;
    logic [15:0] quiet_count;
  } out_t;

endpackage

// File: design/esg_cfg.sv
module esg_cfg import esg_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [VALUE_BITS-1:0] gain,
  output logic [15:0]           interval,
  output logic [VALUE_BITS-1:0] limit [LIM_SLOTS]
);

  localparam logic [63:0] ONE64   = 64'd1 << VALUE_BITS;
  localparam logic [63:0] P5_64   = (ONE64 * 5 + 50) / 100;
  localparam logic [63:0] P8_64   = (ONE64 * 8 + 50) / 100;
  localparam logic [63:0] P10_64  = (ONE64 * 10 + 50) / 100;
  localparam logic [63:0] P12_64  = (ONE64 * 12 + 50) / 100;
  localparam logic [63:0] P15_64  = (ONE64 * 15 + 50) / 100;
  localparam logic [63:0] PRST_64 = {48'd0, PRECISION_RST} & (ONE64 - 64'd1);
  localparam logic [63:0] LRST_64 = P5_64 + (((ONE64 - PRST_64) * P15_64) >> VALUE_BITS);

  localparam logic [VALUE_BITS-1:0] P5  = P5_64[VALUE_BITS-1:0];
  localparam logic [VALUE_BITS-1:0] P8  = P8_64[VALUE_BITS-1:0];
  localparam logic [VALUE_BITS-1:0] P10 = P10_64[VALUE_BITS-1:0];
  localparam logic [VALUE_BITS-1:0] P12 = P12_64[VALUE_BITS-1:0];
  localparam logic [VALUE_BITS-1:0] P15 = P15_64[VALUE_BITS-1:0];

  localparam logic [VALUE_BITS-1:0]   LEVEL_RST = LRST_64[VALUE_BITS-1:0];
  localparam logic [CFG_DATA_W+VALUE_BITS-1:0] GAIN_RST_W =
    {{VALUE_BITS{1'b0}}, GAIN_RST};

  logic                  adaptive;
  logic [VALUE_BITS-1:0] level_tone;
  logic [VALUE_BITS-1:0] level_entity;
  logic [VALUE_BITS-1:0] level_source;

  // precision fractions keep only the low VALUE_BITS bits
  logic [CFG_DATA_W+VALUE_BITS-1:0] data_wide;
  logic [VALUE_BITS-1:0]            data_frac;
  logic [VALUE_BITS:0]              inv;
  logic [2*VALUE_BITS:0]            scaled;
  logic [VALUE_BITS-1:0]            level;

  assign data_wide = {{VALUE_BITS{1'b0}}, cfg_data};
  assign data_frac = data_wide[VALUE_BITS-1:0];
  assign inv       = (VALUE_BITS+1)'(ONE64) - {1'b0, data_frac};
  assign scaled    = {{VALUE_BITS{1'b0}}, inv} * {{(VALUE_BITS+1){1'b0}}, P15};
  assign level     = P5 + scaled[2*VALUE_BITS-1:VALUE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      adaptive     <= 1'b0;
      gain         <= GAIN_RST_W[VALUE_BITS-1:0];
      interval     <= INTERVAL_RST;
      level_tone   <= LEVEL_RST;
      level_entity <= LEVEL_RST;
      level_source <= LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADAPTIVE: adaptive     <= cfg_data[0];
        CFG_GAIN:     gain         <= data_frac;
        CFG_INTERVAL: interval     <= cfg_data;
        CFG_TONE:     level_tone   <= level;
        CFG_ENTITY:   level_entity <= level;
        CFG_SOURCE:   level_source <= level;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (adaptive) begin
      limit[LIM_AUDIO]  = level_tone;
      limit[LIM_CAMERA] = level_entity;
      limit[LIM_SCREEN] = level_entity;
      limit[LIM_BODY]   = level_source;
    end else begin
      limit[LIM_AUDIO]  = P8;
      limit[LIM_CAMERA] = P12;
      limit[LIM_SCREEN] = P10;
      limit[LIM_BODY]   = P15;
    end
    limit[LIM_OTHER] = P10;
  end

endmodule

// File: design/ema_surprise_gate_unit.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_data  (in_t: func, channel, sample, flag, time)
// out      output     out_valid/out_stall out_data (out_t: forward, predicted, quiet count)
// cfg      input      cfg_we              cfg_index, cfg_data
//
// One transaction per cycle sustained while the output is not stalled.
// The input register feeds one signed multiply (EMA step) and the threshold compare,
// which write the channel state and the result register at the same edge.
// Reset (rst, synchronous) clears all channel state and loads register defaults.
// A stalled result holds; the input register keeps taking transactions while the
// result register is free or being taken.
module ema_surprise_gate_unit import esg_pkg::*; #(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // the channel field reaches eight channels at most
  localparam int STORE_CH = (CHANNELS < 8) ? CHANNELS : 8;
  localparam int IDX_W    = $clog2(STORE_CH);

  logic [VALUE_BITS-1:0] gain;
  logic [15:0]           interval;
  logic [VALUE_BITS-1:0] limit [LIM_SLOTS];

  esg_cfg #(.VALUE_BITS(VALUE_BITS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .gain      (gain),
    .interval  (interval),
    .limit     (limit)
  );

  // channel state
  logic [VALUE_BITS-1:0] avg_q [STORE_CH];
  logic                  vld_q [STORE_CH];
  logic [31:0]           hb_q  [STORE_CH];
  logic [15:0]           run_q [STORE_CH];

  // input register
  logic in_full;
  in_t  item;
  logic advance;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // per-item datapath
  logic [IDX_W-1:0]             idx;
  logic                         ch_ok;
  logic [VALUE_BITS-1:0]        avg;
  logic                         vld;
  logic [31:0]                  hb;
  logic [15:0]                  run;
  logic [VALUE_BITS+15:0]       x_wide;
  logic [VALUE_BITS-1:0]        x;
  logic [VALUE_BITS-1:0]        diff;
  logic [VALUE_BITS-1:0]        lim_sel;
  logic                         surprise;
  logic                         hb_due;
  logic [VALUE_BITS-1:0]        base;
  logic signed [VALUE_BITS:0]   delta;
  logic signed [2*VALUE_BITS+1:0] prod;
  logic signed [2*VALUE_BITS+1:0] step_q;
  logic [VALUE_BITS-1:0]        blended;

  assign idx    = item.channel[IDX_W-1:0];
  assign ch_ok  = 32'(item.channel) < 32'(CHANNELS);
  assign avg    = avg_q[idx];
  assign vld    = vld_q[idx];
  assign hb     = hb_q[idx];
  assign run    = run_q[idx];
  assign x_wide = {{VALUE_BITS{1'b0}}, item.sample_value};
  assign x      = x_wide[VALUE_BITS-1:0];
  assign diff   = (x > avg) ? (x - avg) : (avg - x);
  assign hb_due = (item.time_ms - hb) > {16'd0, interval};

  always_comb begin
    unique case (item.channel)
      CH_AUDIO:  lim_sel = limit[LIM_AUDIO];
      CH_CAMERA: lim_sel = limit[LIM_CAMERA];
      CH_SCREEN: lim_sel = limit[LIM_SCREEN];
      CH_BODY:   lim_sel = limit[LIM_BODY];
      default:   lim_sel = limit[LIM_OTHER];
    endcase
  end

  assign surprise = !vld || (diff > lim_sel);

  // (g*x + (1-g)*e) >> n equals e + floor(g*(x-e) / 2^n): one multiply
  assign base    = vld ? avg : x;
  assign delta   = $signed({1'b0, x}) - $signed({1'b0, base});
  assign prod    = $signed({1'b0, gain}) * delta;
  assign step_q  = prod >>> VALUE_BITS;
  assign blended = base + step_q[VALUE_BITS-1:0];

  logic                  wr_clear;
  logic                  wr_blend;
  logic                  wr_hb;
  logic [15:0]           run_next;
  logic                  fwd;
  logic [VALUE_BITS-1:0] pred;
  logic [15:0]           quiet;

  always_comb begin
    wr_clear = 1'b0;
    wr_blend = 1'b0;
    wr_hb    = 1'b0;
    run_next = run;
    fwd      = 1'b0;
    pred     = '0;
    quiet    = '0;
    priority if (!ch_ok) begin
    end else if (item.func == FUNC_CLEAR) begin
      wr_clear = 1'b1;
    end else if (item.semantic_flag) begin
      fwd   = 1'b1;
      pred  = vld ? avg : '0;
      quiet = run;
    end else if (hb_due) begin
      wr_hb    = 1'b1;
      wr_blend = 1'b1;
      fwd      = 1'b1;
      pred     = blended;
      quiet    = run;
    end else begin
      wr_blend = 1'b1;
      if (surprise) begin
        run_next = '0;
      end else if (run != QUIET_MAX) begin
        run_next = run + 16'd1;
      end
      fwd   = surprise;
      pred  = blended;
      quiet = run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_CH; i++) begin
        avg_q[i] <= '0;
        vld_q[i] <= 1'b0;
        hb_q[i]  <= '0;
        run_q[i] <= '0;
      end
    end else if (advance) begin
      if (wr_clear) begin
        avg_q[idx] <= '0;
        vld_q[idx] <= 1'b0;
        hb_q[idx]  <= '0;
        run_q[idx] <= '0;
      end else if (wr_blend) begin
        avg_q[idx] <= blended;
        vld_q[idx] <= 1'b1;
        run_q[idx] <= run_next;
        if (wr_hb) begin
          hb_q[idx] <= item.time_ms;
        end
      end
    end
  end

  // result register
  logic [VALUE_BITS+15:0] pred_wide;
  assign pred_wide = {16'd0, pred};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.forward         <= fwd;
      out_data.predicted_value <= pred_wide[15:0];
      out_data.quiet_count     <= quiet;
    end
  end

endmodule

// File: tb/tb_ema_surprise_gate_unit.sv
module tb_ema_surprise_gate_unit;
  import esg_pkg::*;

  localparam int unsigned ONE_Q16 = 65536;
  localparam int unsigned LIM_5   = ((5 << 16) + 50) / 100;
  localparam int unsigned LIM_8   = ((8 << 16) + 50) / 100;
  localparam int unsigned LIM_10  = ((10 << 16) + 50) / 100;
  localparam int unsigned LIM_12  = ((12 << 16) + 50) / 100;
  localparam int unsigned LIM_15  = ((15 << 16) + 50) / 100;
  localparam int STEADY_ITEMS = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ADAPTIVE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ema_surprise_gate_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // gate model: registers and per-channel state
  bit          adaptive_on;
  logic [15:0] ema_gain;
  logic [15:0] hb_interval;
  logic [15:0] tone_p, entity_p, source_p;
  logic [15:0] ema_val  [8];
  bit          ema_set  [8];
  logic [31:0] beat_ms  [8];
  logic [15:0] calm_run [8];

  out_t pending_results[$];
  int   mismatch_count = 0;

  logic [31:0] now_ms = '0;
  int   burst_left = 0;
  bit   steady_feed = 1'b0;

  function automatic int unsigned adapt_limit(logic [15:0] p);
    longint unsigned inv;
    inv = ONE_Q16 - p;
    return LIM_5 + int'((inv * LIM_15) >> 16);
  endfunction

  function automatic int unsigned surprise_limit(logic [2:0] ch);
    if (adaptive_on) begin
      case (ch)
        CH_AUDIO:             return adapt_limit(tone_p);
        CH_CAMERA, CH_SCREEN: return adapt_limit(entity_p);
        CH_BODY:              return adapt_limit(source_p);
        default:              return LIM_10;
      endcase
    end
    case (ch)
      CH_AUDIO:  return LIM_8;
      CH_CAMERA: return LIM_12;
      CH_SCREEN: return LIM_10;
      CH_BODY:   return LIM_15;
      default:   return LIM_10;
    endcase
  endfunction

  // seed an empty average, then take one truncating EMA step
  function automatic void ema_blend(logic [2:0] ch, logic [15:0] v);
    longint unsigned g, e, acc;
    g = ema_gain;
    if (!ema_set[ch]) begin
      ema_val[ch] = v;
      ema_set[ch] = 1'b1;
    end
    e = ema_val[ch];
    acc = g * v + (ONE_Q16 - g) * e;
    ema_val[ch] = 16'(acc >> 16);
  endfunction

  function automatic out_t gate_step(in_t t);
    out_t r;
    logic [2:0] ch;
    logic [31:0] elapsed;
    int unsigned gap_abs;
    bit surprise;
    r = '0;
    ch = t.channel;
    if (t.func == FUNC_CLEAR) begin
      ema_val[ch] = '0;
      ema_set[ch] = 1'b0;
      beat_ms[ch] = '0;
      calm_run[ch] = '0;
      return r;
    end
    elapsed = t.time_ms - beat_ms[ch];
    if (t.semantic_flag) begin
      r.forward = 1'b1;
    end else if (elapsed > {16'd0, hb_interval}) begin
      beat_ms[ch] = t.time_ms;
      ema_blend(ch, t.sample_value);
      r.forward = 1'b1;
    end else begin
      if (!ema_set[ch]) begin
        surprise = 1'b1;
      end else begin
        gap_abs = (t.sample_value > ema_val[ch]) ? t.sample_value - ema_val[ch]
                                                 : ema_val[ch] - t.sample_value;
        surprise = gap_abs > surprise_limit(ch);
      end
      if (surprise) calm_run[ch] = '0;
      else if (calm_run[ch] != QUIET_MAX) calm_run[ch] = calm_run[ch] + 16'd1;
      ema_blend(ch, t.sample_value);
      r.forward = surprise;
    end
    r.predicted_value = ema_set[ch] ? ema_val[ch] : 16'd0;
    r.quiet_count = calm_run[ch];
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // result checker
  out_t head_result;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result with no pending transaction");
      end else begin
        head_result = pending_results.pop_front();
        if (out_data.forward !== head_result.forward)
          log_mismatch($sformatf("forward got %0b want %0b",
                                 out_data.forward, head_result.forward));
        if (out_data.predicted_value !== head_result.predicted_value)
          log_mismatch($sformatf("predicted_value got %0h want %0h",
                                 out_data.predicted_value, head_result.predicted_value));
        if (out_data.quiet_count !== head_result.quiet_count)
          log_mismatch($sformatf("quiet_count got %0d want %0d",
                                 out_data.quiet_count, head_result.quiet_count));
      end
    end
  end

  // receiver back-pressure: mode is redrawn whenever the low eight bits of sink_tick reach zero
  logic [15:0] sink_tick = '0;
  int sink_mode = 0;
  always @(posedge clk) begin
    sink_tick <= sink_tick + 16'd1;
    if (sink_tick[7:0] == 8'd0) sink_mode <= $urandom_range(0, 3);
    case (sink_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 4) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= (sink_tick[3:1] == 3'b101);
    endcase
  end

  // drive one transaction, hold until taken, then log what it should produce
  task automatic push_txn(input in_t t, input bit use_typed, input out_t typed);
    int gap;
    out_t model_r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 && !steady_feed) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_r = gate_step(t);
    pending_results.push_back(use_typed ? typed : model_r);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic set_config(input bit mode, input logic [15:0] gain, input logic [15:0] ivl,
                            input logic [15:0] tp, input logic [15:0] ep,
                            input logic [15:0] sp);
    write_reg(CFG_ADAPTIVE, {15'd0, mode});
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_INTERVAL, ivl);
    write_reg(CFG_TONE, tp);
    write_reg(CFG_ENTITY, ep);
    write_reg(CFG_SOURCE, sp);
    cfg_we <= 1'b0;
    @(posedge clk);
    adaptive_on = mode;
    ema_gain = gain;
    hb_interval = ivl;
    tone_p = tp;
    entity_p = ep;
    source_p = sp;
  endtask

  // mostly near the channel average, straddling its threshold
  function automatic logic [15:0] pick_sample(logic [2:0] ch);
    int unsigned roll, span, delta;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 8) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    if (roll < 25 || !ema_set[ch]) return 16'($urandom_range(0, 65535));
    span = surprise_limit(ch);
    delta = $urandom_range(0, 2 * span + 2);
    v = ($urandom_range(0, 1) != 0) ? int'(ema_val[ch]) + int'(delta)
                                    : int'(ema_val[ch]) - int'(delta);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic random_run(input int count);
    in_t t;
    for (int n = 0; n < count; n++) begin
      t.channel = 3'($urandom_range(0, 7));
      t.func = ($urandom_range(0, 99) < 4) ? FUNC_CLEAR : FUNC_SAMPLE;
      t.semantic_flag = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) == 0) now_ms = now_ms + $urandom;
      else now_ms = now_ms + $urandom_range(0, hb_interval / 64 + 2);
      t.time_ms = now_ms;
      t.sample_value = pick_sample(t.channel);
      // occasionally let the pipe run dry mid-stream
      if ($urandom_range(0, 199) == 0) drain_all();
      push_txn(t, 1'b0, '0);
    end
  endtask

  typedef struct {
    in_t  stim;
    bit   typed;
    out_t want;
  } dir_row_t;

  function automatic dir_row_t mk_row(logic fn, logic [2:0] ch, logic [15:0] v, int fl,
                                      logic [31:0] ms, int ty, int fw,
                                      logic [15:0] pv, int qc);
    dir_row_t r;
    r.stim.func = fn;
    r.stim.channel = ch;
    r.stim.sample_value = v;
    r.stim.semantic_flag = fl[0];
    r.stim.time_ms = ms;
    r.typed = ty[0];
    r.want.forward = fw[0];
    r.want.predicted_value = pv;
    r.want.quiet_count = qc[15:0];
    return r;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    in_t t;
    adaptive_on = 1'b0;
    ema_gain = GAIN_RST;
    hb_interval = INTERVAL_RST;
    tone_p = PRECISION_RST;
    entity_p = PRECISION_RST;
    source_p = PRECISION_RST;
    for (int c = 0; c < 8; c++) begin
      ema_val[c] = '0;
      ema_set[c] = 1'b0;
      beat_ms[c] = '0;
      calm_run[c] = '0;
    end

    // directed rows under reset register values
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_AUDIO, 16'h1000, 0, 100, 1, 1, 16'h1000, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_AUDIO, 16'h1000, 0, 200, 1, 0, 16'h1000, 1));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_AUDIO, 16'h247B, 0, 300, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_AUDIO, 16'hFFFF, 0, 400, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_CAMERA, 16'hABCD, 1, 400, 1, 1, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_CAMERA, 16'h0000, 0, 500, 1, 1, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_CAMERA, 16'hFFFF, 0, 600, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_SCREEN, 16'hFFFF, 0, 32'hFFFF_FFFF,
                              1, 1, 16'hFFFF, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_SCREEN, 16'hFFFF, 0, 32'hFFFF_FFFF,
                              1, 0, 16'hFFFF, 1));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_SCREEN, 16'h1234, 1, 0, 1, 1, 16'hFFFF, 1));
    dir_rows.push_back(mk_row(FUNC_CLEAR, CH_SCREEN, 16'hFFFF, 1, 32'hFFFF_FFFF,
                              1, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_SCREEN, 16'h8000, 0, 5000, 1, 1, 16'h8000, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_SCREEN, 16'h8000, 0, 5001, 1, 1, 16'h8000, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_BODY, 16'h4000, 0, 10, 1, 1, 16'h4000, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_BODY, 16'h6667, 0, 20, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_BODY, 16'h0000, 1, 30, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, 3'd4, 16'h7FFF, 0, 40, 1, 1, 16'h7FFF, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, 3'd5, 16'h0001, 0, 40, 1, 1, 16'h0001, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, 3'd6, 16'hAAAA, 0, 40, 1, 1, 16'hAAAA, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, 3'd7, 16'h5555, 0, 40, 1, 1, 16'h5555, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, 3'd7, 16'h6EEF, 0, 50, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_CLEAR, CH_AUDIO, 16'h0000, 0, 0, 1, 0, 0, 0));
    dir_rows.push_back(mk_row(FUNC_SAMPLE, CH_AUDIO, 16'h0000, 0, 0, 1, 1, 0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) push_txn(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);
    drain_all();

    set_config(1'b1, GAIN_RST, 16'd5000, 16'h0000, 16'h8000, 16'hFFFF);
    now_ms = 32'h0000_1000;
    random_run(320);
    drain_all();

    // zero gain, interval of 1, time crossing the 32-bit wrap
    set_config(1'b1, 16'h0000, 16'd1, 16'hFFFF, 16'h0000, 16'd12345);
    now_ms = 32'hFFFF_FF00;
    random_run(320);
    drain_all();

    set_config(1'b0, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003);
    now_ms = '0;
    random_run(320);
    drain_all();

    set_config(1'b1, 16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    now_ms = $urandom;
    random_run(320);
    drain_all();

    set_config(1'b0, 16'h0001, 16'd300, 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    random_run(320);
    drain_all();

    // hold one channel steady back to back so the quiet count climbs
    set_config(1'b0, GAIN_RST, INTERVAL_RST, PRECISION_RST, PRECISION_RST, PRECISION_RST);
    steady_feed = 1'b1;
    t = '0;
    t.func = FUNC_CLEAR;
    t.channel = 3'd5;
    push_txn(t, 1'b0, '0);
    t.func = FUNC_SAMPLE;
    t.sample_value = 16'h2345;
    for (int n = 0; n < STEADY_ITEMS; n++) push_txn(t, 1'b0, '0);
    t.semantic_flag = 1'b1;
    push_txn(t, 1'b0, '0);
    steady_feed = 1'b0;

    drain_all();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) log_mismatch("results still pending at end of run");
    if (mismatch_count == 0) begin
      $display("tb_ema_surprise_gate_unit: PASS");
    end else begin
      $display("tb_ema_surprise_gate_unit: FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_ema_surprise_gate_unit: FAIL");
    $finish;
  end

endmodule

// File: files.f
design/esg_pkg.sv
design/esg_cfg.sv
design/ema_surprise_gate_unit.sv
tb/tb_ema_surprise_gate_unit.sv
